### hdl/i2cm_pkg.sv
// shared types and constants for the bit-level i2c master
// no dependencies
package i2cm_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_WAIT  = 3'd4,
        OP_READ  = 3'd5
    } t_op;

    localparam logic CFG_ACK_TIMEOUT = 1'b0;
    localparam logic CFG_DELAY_SCALE = 1'b1;

    localparam logic [7:0] C_ACK_TIMEOUT_RST = 8'd250;
    localparam logic [7:0] C_DELAY_SCALE_RST = 8'd1;

    typedef struct packed {
        logic [7:0] ack_timeout;
        logic [7:0] delay_scale;
    } t_cfg;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive_low;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_error;
        logic       cmd_rejected;
    } t_result;

endpackage

### hdl/i2cm_seq.sv
// phase sequencer: next state from one request, state and result registers
// depends on i2cm_pkg
module i2cm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_tx_byte,
    input  logic              i_send_ack,
    input  logic              i_sda_sample,
    input  i2cm_pkg::t_cfg    i_cfg,
    output i2cm_pkg::t_result o_res
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST_A = 5'd1,
        PH_ST_B = 5'd2,
        PH_SP_A = 5'd3,
        PH_SP_B = 5'd4,
        PH_WR_A = 5'd5,
        PH_WR_B = 5'd6,
        PH_WR_C = 5'd7,
        PH_WA_A = 5'd8,
        PH_WA_B = 5'd9,
        PH_RD_A = 5'd10,
        PH_RD_B = 5'd11,
        PH_AK_A = 5'd12,
        PH_AK_B = 5'd13
    } t_phase;

    t_phase     r_phase,     n_phase;
    logic [9:0] r_delay,     n_delay;
    logic [3:0] r_bit_idx,   n_bit_idx;
    logic [7:0] r_shift,     n_shift;
    logic [7:0] r_poll,      n_poll;
    logic       r_ack_choice, n_ack_choice;
    logic       r_scl,       n_scl;
    logic       r_sda_low,   n_sda_low;
    logic       r_err,       n_err;
    logic [7:0] r_rx,        n_rx;
    logic       r_done,      n_done;
    logic       r_rej,       n_rej;

    logic [7:0] scale;
    logic [9:0] d1, d2, d4;
    logic [3:0] bit_inc;

    // zero scale acts as one
    assign scale   = (i_cfg.delay_scale == 8'd0) ? 8'd1 : i_cfg.delay_scale;
    assign d1      = {2'b00, scale};
    assign d2      = {1'b0, scale, 1'b0};
    assign d4      = {scale, 2'b00};
    assign bit_inc = r_bit_idx + 4'd1;

    always_comb begin
        n_phase      = r_phase;
        n_delay      = r_delay;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_poll       = r_poll;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda_low    = r_sda_low;
        n_err        = r_err;
        n_rx         = r_rx;
        n_done       = 1'b0;
        n_rej        = 1'b0;

        unique case (t_op'(i_op))
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_delay > 10'd1) begin
                        n_delay = r_delay - 10'd1;
                    end else begin
                        n_delay = 10'd0;
                        unique case (r_phase)
                            PH_ST_A: begin
                                n_sda_low = 1'b1;
                                n_delay   = d4;
                                n_phase   = PH_ST_B;
                            end
                            PH_ST_B: begin
                                n_scl   = 1'b0;
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end
                            PH_SP_A: begin
                                n_scl     = 1'b1;
                                n_sda_low = 1'b0;
                                n_delay   = d4;
                                n_phase   = PH_SP_B;
                            end
                            PH_SP_B: begin
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end
                            PH_WR_A: begin
                                n_scl   = 1'b1;
                                n_delay = d2;
                                n_phase = PH_WR_B;
                            end
                            PH_WR_B: begin
                                n_scl   = 1'b0;
                                n_delay = d2;
                                n_phase = PH_WR_C;
                            end
                            PH_WR_C: begin
                                n_bit_idx = bit_inc;
                                if (bit_inc < 4'd8) begin
                                    n_shift   = {r_shift[6:0], 1'b0};
                                    n_sda_low = ~r_shift[6];
                                    n_delay   = d2;
                                    n_phase   = PH_WR_A;
                                end else begin
                                    n_phase = PH_IDLE;
                                    n_done  = 1'b1;
                                end
                            end
                            PH_WA_A: begin
                                n_scl   = 1'b1;
                                n_delay = d1;
                                n_phase = PH_WA_B;
                            end
                            PH_WA_B: begin
                                if (!i_sda_sample) begin
                                    n_scl   = 1'b0;
                                    n_err   = 1'b0;
                                    n_phase = PH_IDLE;
                                    n_done  = 1'b1;
                                end else if (r_poll >= i_cfg.ack_timeout) begin
                                    // ack timeout: flag and run a stop
                                    n_err     = 1'b1;
                                    n_scl     = 1'b0;
                                    n_sda_low = 1'b1;
                                    n_delay   = d4;
                                    n_phase   = PH_SP_A;
                                end else begin
                                    n_poll = r_poll + 8'd1;
                                end
                            end
                            PH_RD_A: begin
                                n_scl   = 1'b1;
                                n_shift = {r_shift[6:0], i_sda_sample};
                                n_delay = d1;
                                n_phase = PH_RD_B;
                            end
                            PH_RD_B: begin
                                n_bit_idx = bit_inc;
                                n_scl     = 1'b0;
                                n_delay   = d2;
                                if (bit_inc < 4'd8) begin
                                    n_phase = PH_RD_A;
                                end else begin
                                    n_sda_low = r_ack_choice;
                                    n_phase   = PH_AK_A;
                                end
                            end
                            PH_AK_A: begin
                                n_scl   = 1'b1;
                                n_delay = d2;
                                n_phase = PH_AK_B;
                            end
                            PH_AK_B: begin
                                n_scl   = 1'b0;
                                n_rx    = r_shift;
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            OP_START, OP_STOP, OP_WRITE, OP_WAIT, OP_READ: begin
                if (r_phase != PH_IDLE) begin
                    n_rej = 1'b1;
                end else begin
                    n_bit_idx = 4'd0;
                    n_poll    = 8'd0;
                    unique case (t_op'(i_op))
                        OP_START: begin
                            n_sda_low = 1'b0;
                            n_scl     = 1'b1;
                            n_delay   = d4;
                            n_phase   = PH_ST_A;
                        end
                        OP_STOP: begin
                            n_scl     = 1'b0;
                            n_sda_low = 1'b1;
                            n_delay   = d4;
                            n_phase   = PH_SP_A;
                        end
                        OP_WRITE: begin
                            n_scl     = 1'b0;
                            n_shift   = i_tx_byte;
                            n_sda_low = ~i_tx_byte[7];
                            n_delay   = d2;
                            n_phase   = PH_WR_A;
                        end
                        OP_WAIT: begin
                            n_err     = 1'b0;
                            n_sda_low = 1'b0;
                            n_delay   = d1;
                            n_phase   = PH_WA_A;
                        end
                        default: begin
                            n_sda_low    = 1'b0;
                            n_shift      = 8'd0;
                            n_ack_choice = i_send_ack;
                            n_scl        = 1'b0;
                            n_delay      = d2;
                            n_phase      = PH_RD_A;
                        end
                    endcase
                end
            end
            default: begin
                // undefined op codes are ignored
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_delay      <= 10'd0;
            r_bit_idx    <= 4'd0;
            r_shift      <= 8'd0;
            r_poll       <= 8'd0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda_low    <= 1'b0;
            r_err        <= 1'b0;
            r_rx         <= 8'd0;
            r_done       <= 1'b0;
            r_rej        <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_delay      <= n_delay;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
            r_poll       <= n_poll;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda_low    <= n_sda_low;
            r_err        <= n_err;
            r_rx         <= n_rx;
            r_done       <= n_done;
            r_rej        <= n_rej;
        end
    end

    assign o_res.scl_level     = r_scl;
    assign o_res.sda_drive_low = r_sda_low;
    assign o_res.busy          = (r_phase != PH_IDLE);
    assign o_res.done          = r_done;
    assign o_res.rx_byte       = r_rx;
    assign o_res.ack_error     = r_err;
    assign o_res.cmd_rejected  = r_rej;

endmodule

### hdl/i2c_bit_level_master.sv
// bit-level i2c master: the result of an accepted request is registered before it is shown
// throughput one request per cycle while o_stall is low; the phase sequencer advances once per request
// the result register frees when taken, so a new request enters while one is taken
// reset is synchronous, active low: registers back to defaults (timeout 250, scale 1),
// scl and sda released, sequencer idle, no result pending
// depends on i2cm_pkg and i2cm_seq
module i2c_bit_level_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_op,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_sda_sample,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_level,
    output logic       o_sda_drive_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_error,
    output logic       o_cmd_rejected
);
    import i2cm_pkg::*;

    t_cfg    r_cfg;
    t_result res;
    logic    r_out_valid;
    logic    accept;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_timeout <= C_ACK_TIMEOUT_RST;
            r_cfg.delay_scale <= C_DELAY_SCALE_RST;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_data;
                    CFG_DELAY_SCALE: r_cfg.delay_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    i2cm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_op),
        .i_tx_byte    (i_tx_byte),
        .i_send_ack   (i_send_ack),
        .i_sda_sample (i_sda_sample),
        .i_cfg        (r_cfg),
        .o_res        (res)
    );

    assign o_valid         = r_out_valid;
    assign o_scl_level     = res.scl_level;
    assign o_sda_drive_low = res.sda_drive_low;
    assign o_busy_res      = res.busy;
    assign o_done_res      = res.done;
    assign o_rx_byte       = res.rx_byte;
    assign o_ack_error     = res.ack_error;
    assign o_cmd_rejected  = res.cmd_rejected;

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted request produced no result");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("sequence done while still busy");

    a_reject_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cmd_rejected |-> o_busy_res && !o_done_res)
        else $error("request rejected while idle or completing");
`endif

endmodule

### sim/tb_i2c_bit_level_master.sv
// self-checking testbench for the bit-level i2c master: predicts scl, sda and status per request
// and compares every result in order, under random idling, stalls and a long output hold-off
// depends on i2cm_pkg and i2c_bit_level_master
module tb_i2c_bit_level_master;
    import i2cm_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WR_A, PH_WR_B, PH_WR_C,
        PH_WA_A, PH_WA_B, PH_RD_A, PH_RD_B, PH_AK_A, PH_AK_B
    } t_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = 1'b0;
    logic [7:0] i_cfg_data = 8'd0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [2:0] i_op = OP_TICK;
    logic [7:0] i_tx_byte = 8'd0;
    logic       i_send_ack = 1'b0;
    logic       i_sda_sample = 1'b1;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_scl_level;
    logic       o_sda_drive_low;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rx_byte;
    logic       o_ack_error;
    logic       o_cmd_rejected;

    t_phase     seq_ph;
    logic [9:0] ticks_left;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [7:0] poll_cnt;
    logic       ack_sel;
    logic       scl_r;
    logic       sda_low_r;
    logic       err_r;
    logic [7:0] rx_hold;
    logic [7:0] timeout_r;
    logic [7:0] scale_r;

    t_result    pending_line_states[$];
    int         fail_count = 0;
    int         req_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_len = 0;

    i2c_bit_level_master DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_tx_byte      (i_tx_byte),
        .i_send_ack     (i_send_ack),
        .i_sda_sample   (i_sda_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_scl_level    (o_scl_level),
        .o_sda_drive_low(o_sda_drive_low),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_rx_byte      (o_rx_byte),
        .o_ack_error    (o_ack_error),
        .o_cmd_rejected (o_cmd_rejected)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic void reset_line_state();
        timeout_r  = C_ACK_TIMEOUT_RST;
        scale_r    = C_DELAY_SCALE_RST;
        seq_ph     = PH_IDLE;
        ticks_left = '0;
        bit_cnt    = '0;
        shreg      = '0;
        poll_cnt   = '0;
        ack_sel    = 1'b0;
        scl_r      = 1'b1;
        sda_low_r  = 1'b0;
        err_r      = 1'b0;
        rx_hold    = '0;
    endfunction

    function automatic void load_delay(int units, t_phase nxt);
        int s;
        s = (scale_r == 8'd0) ? 1 : int'(scale_r);
        ticks_left = 10'(units * s);
        seq_ph = nxt;
    endfunction

    function automatic void start_stop_seq();
        scl_r = 1'b0;
        sda_low_r = 1'b1;
        load_delay(4, PH_SP_A);
    endfunction

    function automatic logic advance_phase(logic sda);
        logic fin;
        fin = 1'b0;
        case (seq_ph)
            PH_ST_A: begin
                sda_low_r = 1'b1;
                load_delay(4, PH_ST_B);
            end
            PH_ST_B: begin
                scl_r = 1'b0;
                seq_ph = PH_IDLE;
                fin = 1'b1;
            end
            PH_SP_A: begin
                scl_r = 1'b1;
                sda_low_r = 1'b0;
                load_delay(4, PH_SP_B);
            end
            PH_SP_B: begin
                seq_ph = PH_IDLE;
                fin = 1'b1;
            end
            PH_WR_A: begin
                scl_r = 1'b1;
                load_delay(2, PH_WR_B);
            end
            PH_WR_B: begin
                scl_r = 1'b0;
                load_delay(2, PH_WR_C);
            end
            PH_WR_C: begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < 4'd8) begin
                    shreg = shreg << 1;
                    sda_low_r = ~shreg[7];
                    load_delay(2, PH_WR_A);
                end else begin
                    seq_ph = PH_IDLE;
                    fin = 1'b1;
                end
            end
            PH_WA_A: begin
                scl_r = 1'b1;
                load_delay(1, PH_WA_B);
            end
            PH_WA_B: begin
                if (!sda) begin
                    scl_r = 1'b0;
                    err_r = 1'b0;
                    seq_ph = PH_IDLE;
                    fin = 1'b1;
                end else if (poll_cnt >= timeout_r) begin
                    err_r = 1'b1;
                    start_stop_seq();
                end else begin
                    poll_cnt = poll_cnt + 8'd1;
                end
            end
            PH_RD_A: begin
                scl_r = 1'b1;
                shreg = {shreg[6:0], sda};
                load_delay(1, PH_RD_B);
            end
            PH_RD_B: begin
                bit_cnt = bit_cnt + 4'd1;
                scl_r = 1'b0;
                if (bit_cnt < 4'd8) begin
                    load_delay(2, PH_RD_A);
                end else begin
                    sda_low_r = ack_sel;
                    load_delay(2, PH_AK_A);
                end
            end
            PH_AK_A: begin
                scl_r = 1'b1;
                load_delay(2, PH_AK_B);
            end
            PH_AK_B: begin
                scl_r = 1'b0;
                rx_hold = shreg;
                seq_ph = PH_IDLE;
                fin = 1'b1;
            end
            default: seq_ph = PH_IDLE;
        endcase
        return fin;
    endfunction

    function automatic t_result next_line_state(logic [2:0] op, logic [7:0] txb, logic ack,
                                                logic sda);
        t_result r;
        logic fin;
        logic rej;
        fin = 1'b0;
        rej = 1'b0;
        if (op == OP_TICK) begin
            if (seq_ph != PH_IDLE) begin
                if (ticks_left > 10'd1) begin
                    ticks_left = ticks_left - 10'd1;
                end else begin
                    ticks_left = '0;
                    fin = advance_phase(sda);
                end
            end
        end else if (op <= OP_READ) begin
            if (seq_ph != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                bit_cnt = '0;
                poll_cnt = '0;
                case (op)
                    OP_START: begin
                        sda_low_r = 1'b0;
                        scl_r = 1'b1;
                        load_delay(4, PH_ST_A);
                    end
                    OP_STOP: start_stop_seq();
                    OP_WRITE: begin
                        scl_r = 1'b0;
                        shreg = txb;
                        sda_low_r = ~txb[7];
                        load_delay(2, PH_WR_A);
                    end
                    OP_WAIT: begin
                        err_r = 1'b0;
                        sda_low_r = 1'b0;
                        load_delay(1, PH_WA_A);
                    end
                    default: begin
                        sda_low_r = 1'b0;
                        shreg = '0;
                        ack_sel = ack;
                        scl_r = 1'b0;
                        load_delay(2, PH_RD_A);
                    end
                endcase
            end
        end
        r.scl_level     = scl_r;
        r.sda_drive_low = sda_low_r;
        r.busy          = (seq_ph != PH_IDLE);
        r.done          = fin;
        r.rx_byte       = rx_hold;
        r.ack_error     = err_r;
        r.cmd_rejected  = rej;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function automatic int pick_low_pct();
        case ($urandom_range(3))
            0: return 5;
            1: return 30;
            2: return 60;
            default: return 100;
        endcase
    endfunction

    task automatic send_req(input logic [2:0] op, input logic [7:0] txb, input logic ack,
                            input logic sda);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_tx_byte    <= txb;
        i_send_ack   <= ack;
        i_sda_sample <= sda;
        do @(posedge i_clk); while (o_stall);
        pending_line_states.push_back(next_line_state(op, txb, ack, sda));
        req_count++;
    endtask

    task automatic release_req();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic settle();
        release_req();
        while (pending_line_states.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ACK_TIMEOUT) timeout_r = val;
        else scale_r = val;
    endtask

    // command, then ticks until the sequencer is idle, with stray requests mixed in
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] txb, input logic ack,
                           input int low_pct, input int noise_pct);
        send_req(op, txb, ack, 1'($urandom));
        while (seq_ph != PH_IDLE) begin
            if ($urandom_range(99) < noise_pct)
                send_req(3'($urandom_range(7, 1)), 8'($urandom), 1'($urandom), 1'($urandom));
            else
                send_req(OP_TICK, 8'($urandom), 1'($urandom),
                         ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1);
        end
    endtask

    task automatic test_start_stop();
        run_cmd(OP_START, 8'h00, 1'b0, 50, 0);
        send_req(OP_TICK, 8'hff, 1'b1, 1'b0);
        send_req(3'd6, 8'h00, 1'b0, 1'b1);
        send_req(3'd7, 8'hff, 1'b1, 1'b0);
        send_req(OP_STOP, 8'h00, 1'b0, 1'b1);
        send_req(OP_WRITE, 8'hff, 1'b1, 1'b1);
        send_req(OP_READ, 8'h00, 1'b0, 1'b0);
        while (seq_ph != PH_IDLE) send_req(OP_TICK, 8'h00, 1'b0, 1'b1);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 100, 0);
    endtask

    task automatic test_write_read();
        run_cmd(OP_WRITE, 8'h80, 1'b0, 50, 0);
        run_cmd(OP_WRITE, 8'h7f, 1'b0, 50, 0);
        run_cmd(OP_READ, 8'h00, 1'b1, 50, 0);
        run_cmd(OP_READ, 8'hff, 1'b0, 50, 0);
    endtask

    task automatic test_ack_timeout_limits();
        settle();
        write_reg(CFG_ACK_TIMEOUT, 8'd255);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 0, 0);
        settle();
        write_reg(CFG_ACK_TIMEOUT, 8'd0);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 0, 0);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 100, 0);
    endtask

    task automatic test_delay_scale_limits();
        settle();
        write_reg(CFG_DELAY_SCALE, 8'd255);
        write_reg(CFG_ACK_TIMEOUT, 8'($urandom));
        run_cmd(OP_WAIT, 8'h00, 1'b0, 100, 0);
        settle();
        write_reg(CFG_DELAY_SCALE, 8'd0);
        run_cmd(OP_START, 8'h00, 1'b0, 50, 0);
    endtask

    task automatic test_random(input logic [7:0] tmo, input logic [7:0] div, input int snd,
                               input int rcv, input int n);
        int stop_at;
        int pick;
        settle();
        write_reg(CFG_ACK_TIMEOUT, tmo);
        write_reg(CFG_DELAY_SCALE, div);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        stop_at = req_count + n;
        while (req_count < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_req(3'($urandom_range(7, 6)), 8'($urandom), 1'($urandom), 1'($urandom));
            else if (pick < 14)
                send_req(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            else
                run_cmd(3'($urandom_range(OP_READ, OP_START)), 8'($urandom), 1'($urandom),
                        pick_low_pct(), 4);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        int stop_at;
        settle();
        write_reg(CFG_ACK_TIMEOUT, 8'd2);
        write_reg(CFG_DELAY_SCALE, 8'd1);
        hold_len = 200;
        stop_at = req_count + 30;
        while (req_count < stop_at)
            run_cmd(3'($urandom_range(OP_READ, OP_START)), 8'($urandom), 1'($urandom),
                    pick_low_pct(), 4);
    endtask

    // receiver side: random stalls plus one long hold-off in the backpressure test
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                i_stall <= 1'b1;
                hold_len--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        t_result exp_r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_line_states.size() == 0) begin
                    $error("result with no request waiting");
                    fail_count++;
                end else begin
                    exp_r = pending_line_states.pop_front();
                    check_field("scl_level", 8'(exp_r.scl_level), 8'(o_scl_level));
                    check_field("sda_drive_low", 8'(exp_r.sda_drive_low),
                                8'(o_sda_drive_low));
                    check_field("busy_res", 8'(exp_r.busy), 8'(o_busy_res));
                    check_field("done_res", 8'(exp_r.done), 8'(o_done_res));
                    check_field("rx_byte", exp_r.rx_byte, o_rx_byte);
                    check_field("ack_error", 8'(exp_r.ack_error), 8'(o_ack_error));
                    check_field("cmd_rejected", 8'(exp_r.cmd_rejected), 8'(o_cmd_rejected));
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("FAIL i2c_bit_level_master");
        $finish;
    end

    initial begin
        reset_line_state();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_start_stop();
        test_write_read();
        test_ack_timeout_limits();
        test_delay_scale_limits();
        test_random(8'd3, 8'd1, 0, 0, 50);
        test_random(8'd0, 8'd2, 73, 0, 50);
        test_random(8'd7, 8'd0, 0, 73, 50);
        test_random(8'($urandom_range(12, 1)), 8'd3, 34, 34, 50);
        test_backpressure();
        settle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS i2c_bit_level_master");
        end else begin
            $display("FAIL i2c_bit_level_master");
        end
        $finish;
    end

endmodule
